// ===== hdl/rrq_pkg.sv =====
// Package for the rotary rotate-and-quantize block.
// Holds widths, register indexes, the CORDIC arctangent table and the
// quantizer settings type. No dependencies.
`timescale 1ns / 1ps
package rrq_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int ANGLE_W      = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int GUARD_BITS   = 8;
  localparam int CODE_W       = 8;
  localparam int QBITS_W      = 4;
  localparam int RANGE_W      = 15;
  localparam int DEN_W        = RANGE_W + GUARD_BITS + 1;
  localparam int KINV_W       = 21;
  localparam int FIFO_DEPTH   = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic signed [KINV_W-1:0] KINV_Q20   = 21'sd636751;
  localparam logic [RANGE_W-1:0]       RANGE_ONE  = 15'd4096;
  localparam logic [QBITS_W-1:0]       QBITS_MAX  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_RANGE = 2'd1;

  typedef struct packed {
    logic [CODE_W-1:0] scale;
    logic [DEN_W-1:0]  den;
  } quant_cfg_t;

  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/rrq_fifo.sv =====
// Short register queue between the front and the back of the block.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module rrq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/rrq_front.sv =====
// Front end: takes the fields of an input transaction, picks the quadrant and does the
// exact quarter-turn pre-rotation with guard bits. Depends on rrq_pkg.
`timescale 1ns / 1ps
module rrq_front #(
  parameter int SAMPLE_WIDTH = rrq_pkg::SAMPLE_W,
  parameter int ANGLE_WIDTH  = rrq_pkg::ANGLE_W,
  parameter int CW           = SAMPLE_WIDTH + 11,
  parameter int FW           = 2 * CW + 32
) (
  input  logic                    [SAMPLE_WIDTH-1:0] coord_x,
  input  logic                    [SAMPLE_WIDTH-1:0] coord_y,
  input  logic                    [ANGLE_WIDTH-1:0]  rot_angle,
  output logic                    [FW-1:0]           item
);

  logic signed [CW-1:0] x, y, px, py;
  logic [31:0]          a32, quad_sum, resid;
  logic [1:0]           quad;

  always_comb begin
    x        = CW'($signed(coord_x));
    y        = CW'($signed(coord_y));
    a32      = {rot_angle, {(32 - ANGLE_WIDTH){1'b0}}};
    quad_sum = a32 + 32'h20000000;
    quad     = quad_sum[31:30];
    resid    = a32 - {quad, 30'b0};
    case (quad)
      2'd1: begin
        px = -y;
        py = x;
      end
      2'd2: begin
        px = -x;
        py = -y;
      end
      2'd3: begin
        px = y;
        py = -x;
      end
      default: begin
        px = x;
        py = y;
      end
    endcase
    item = {px <<< rrq_pkg::GUARD_BITS, py <<< rrq_pkg::GUARD_BITS, resid};
  end

endmodule

// ===== hdl/rrq_back.sv =====
// Back end: 24-stage CORDIC pipeline, gain correction, and a quantizer with
// an 8-stage restoring divider. Depends on rrq_pkg.
`timescale 1ns / 1ps
module rrq_back #(
  parameter int SAMPLE_WIDTH = rrq_pkg::SAMPLE_W,
  parameter int CW           = SAMPLE_WIDTH + 11,
  parameter int FW           = 2 * CW + 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_valid,
  input  logic [FW-1:0]                        item,
  output logic                                 item_pop,
  input  rrq_pkg::quant_cfg_t                  qcfg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rrq_pkg::CODE_W-1:0]           code_x,
  output logic [rrq_pkg::CODE_W-1:0]           code_y
);

  localparam int NS  = rrq_pkg::CORDIC_STEPS;
  localparam int VW  = SAMPLE_WIDTH + 10;
  localparam int PW  = CW + rrq_pkg::KINV_W;
  localparam int NW  = VW + rrq_pkg::RANGE_W + 20;
  localparam int QW  = rrq_pkg::CODE_W;
  localparam int DW  = rrq_pkg::DEN_W;

  logic en;

  logic                 cv_r [NS+1];
  logic signed [CW-1:0] cx_r [NS+1];
  logic signed [CW-1:0] cy_r [NS+1];
  logic signed [31:0]   cz_r [NS+1];
  logic signed [CW-1:0] cx_nxt [NS];
  logic signed [CW-1:0] cy_nxt [NS];
  logic signed [31:0]   cz_nxt [NS];

  logic                 gv_r;
  logic signed [VW-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic signed [PW-1:0] prod_x, prod_y;

  logic                 nv_r;
  logic signed [NW-1:0] nx_r, ny_r, nx_nxt, ny_nxt, bias;

  logic          dv_r [QW+1];
  logic [NW-2:0] rx_r [QW+1];
  logic [NW-2:0] ry_r [QW+1];
  logic [QW-1:0] qx_r [QW+1];
  logic [QW-1:0] qy_r [QW+1];
  logic          zx_r [QW+1];
  logic          zy_r [QW+1];
  logic          sx_r [QW+1];
  logic          sy_r [QW+1];
  logic [NW-2:0] rx_nxt [QW+1];
  logic [NW-2:0] ry_nxt [QW+1];
  logic [QW-1:0] qx_nxt [QW+1];
  logic [QW-1:0] qy_nxt [QW+1];
  logic          sx_nxt, sy_nxt;

  logic                 ov_r;
  logic [QW-1:0]        ox_r, oy_r, ox_nxt, oy_nxt;
  logic [NW-2:0]        den_top;

  assign en        = !ov_r || out_ready;
  assign item_pop  = en;
  assign out_valid = ov_r;
  assign code_x    = ox_r;
  assign code_y    = oy_r;

  always_comb begin
    logic signed [CW-1:0] dx, dy;
    logic [31:0]          at;
    for (int i = 0; i < NS; i++) begin
      dx = cy_r[i] >>> i;
      dy = cx_r[i] >>> i;
      at = rrq_pkg::atan_turn(i);
      if (!cz_r[i][31]) begin
        cx_nxt[i] = cx_r[i] - dx;
        cy_nxt[i] = cy_r[i] + dy;
        cz_nxt[i] = cz_r[i] - $signed(at);
      end else begin
        cx_nxt[i] = cx_r[i] + dx;
        cy_nxt[i] = cy_r[i] - dy;
        cz_nxt[i] = cz_r[i] + $signed(at);
      end
    end
  end

  always_comb begin
    prod_x = PW'(cx_r[NS]) * PW'(rrq_pkg::KINV_Q20) + PW'(1 << 19);
    prod_y = PW'(cy_r[NS]) * PW'(rrq_pkg::KINV_Q20) + PW'(1 << 19);
    gx_nxt = VW'(prod_x >>> 20);
    gy_nxt = VW'(prod_y >>> 20);
  end

  always_comb begin
    logic signed [NW-1:0] s_ext, r_ext;
    s_ext  = $signed({{(NW - QW){1'b0}}, qcfg.scale});
    r_ext  = $signed({{(NW - DW){1'b0}}, qcfg.den});
    bias   = (r_ext >>> 1) * (s_ext + NW'(1));
    nx_nxt = NW'(gx_r) * s_ext + bias;
    ny_nxt = NW'(gy_r) * s_ext + bias;
    den_top = (NW-1)'(qcfg.den) << QW;
    sx_nxt  = (nx_r[NW-2:0] >= den_top);
    sy_nxt  = (ny_r[NW-2:0] >= den_top);
  end

  always_comb begin
    logic [NW-2:0] t;
    rx_nxt[0] = '0;
    ry_nxt[0] = '0;
    qx_nxt[0] = '0;
    qy_nxt[0] = '0;
    for (int j = 0; j < QW; j++) begin
      t = (NW-1)'(qcfg.den) << (QW - 1 - j);
      rx_nxt[j+1] = rx_r[j];
      ry_nxt[j+1] = ry_r[j];
      qx_nxt[j+1] = qx_r[j];
      qy_nxt[j+1] = qy_r[j];
      if (rx_r[j] >= t) begin
        rx_nxt[j+1] = rx_r[j] - t;
        qx_nxt[j+1][QW-1-j] = 1'b1;
      end
      if (ry_r[j] >= t) begin
        ry_nxt[j+1] = ry_r[j] - t;
        qy_nxt[j+1][QW-1-j] = 1'b1;
      end
    end
  end

  always_comb begin
    if (zx_r[QW]) begin
      ox_nxt = '0;
    end else if (sx_r[QW] || qx_r[QW] > qcfg.scale) begin
      ox_nxt = qcfg.scale;
    end else begin
      ox_nxt = qx_r[QW];
    end
    if (zy_r[QW]) begin
      oy_nxt = '0;
    end else if (sy_r[QW] || qy_r[QW] > qcfg.scale) begin
      oy_nxt = qcfg.scale;
    end else begin
      oy_nxt = qy_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) begin
        cv_r[i] <= 1'b0;
      end
      gv_r <= 1'b0;
      nv_r <= 1'b0;
      for (int j = 0; j <= QW; j++) begin
        dv_r[j] <= 1'b0;
      end
      ov_r <= 1'b0;
    end else if (en) begin
      cv_r[0] <= item_valid;
      for (int i = 0; i < NS; i++) begin
        cv_r[i+1] <= cv_r[i];
      end
      gv_r    <= cv_r[NS];
      nv_r    <= gv_r;
      dv_r[0] <= nv_r;
      for (int j = 0; j < QW; j++) begin
        dv_r[j+1] <= dv_r[j];
      end
      ov_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0] <= $signed(item[FW-1 -: CW]);
      cy_r[0] <= $signed(item[32 +: CW]);
      cz_r[0] <= $signed(item[31:0]);
      for (int i = 0; i < NS; i++) begin
        cx_r[i+1] <= cx_nxt[i];
        cy_r[i+1] <= cy_nxt[i];
        cz_r[i+1] <= cz_nxt[i];
      end
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      nx_r <= nx_nxt;
      ny_r <= ny_nxt;
      rx_r[0] <= nx_r[NW-2:0];
      ry_r[0] <= ny_r[NW-2:0];
      qx_r[0] <= qx_nxt[0];
      qy_r[0] <= qy_nxt[0];
      zx_r[0] <= nx_r[NW-1];
      zy_r[0] <= ny_r[NW-1];
      sx_r[0] <= sx_nxt;
      sy_r[0] <= sy_nxt;
      for (int j = 0; j < QW; j++) begin
        rx_r[j+1] <= rx_nxt[j+1];
        ry_r[j+1] <= ry_nxt[j+1];
        qx_r[j+1] <= qx_nxt[j+1];
        qy_r[j+1] <= qy_nxt[j+1];
        zx_r[j+1] <= zx_r[j];
        zy_r[j+1] <= zy_r[j];
        sx_r[j+1] <= sx_r[j];
        sy_r[j+1] <= sy_r[j];
      end
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
  end

endmodule

// ===== hdl/rotary_rotate_and_quantize_top.sv =====
// From an accepted input transaction to out_tvalid: queue, CORDIC, gain, scaling, divider and output registers.
// Throughput: one transaction per cycle unless out_tready stalls, set by the fully pipelined CORDIC and divider.
// A four-entry queue sits between the pre-rotation front and the pipeline.
// Reset (rst_n low, synchronous) empties the queue and the pipeline and sets
// quant_bits to 8 and value_range to 4096.
`timescale 1ns / 1ps
module rotary_rotate_and_quantize_top #(
  parameter int SAMPLE_WIDTH = rrq_pkg::SAMPLE_W,
  parameter int ANGLE_WIDTH  = rrq_pkg::ANGLE_W
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // coord_x, coord_y, rot_angle, zero fill
  input  logic [((2*SAMPLE_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // code_x, code_y
  output logic [2*rrq_pkg::CODE_W-1:0] out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rrq_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [rrq_pkg::RANGE_W-1:0]       cfg_wdata
);

  localparam int CW = SAMPLE_WIDTH + 11;
  localparam int FW = 2 * CW + 32;

  logic [rrq_pkg::QBITS_W-1:0] qbits_r;
  logic [rrq_pkg::RANGE_W-1:0] range_r;
  logic [rrq_pkg::QBITS_W-1:0] qbits_eff;
  logic [rrq_pkg::RANGE_W-1:0] range_eff;
  rrq_pkg::quant_cfg_t         qcfg;
  logic [FW-1:0]               front_item, q_item;
  logic                        q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qbits_r <= rrq_pkg::QBITS_MAX;
      range_r <= rrq_pkg::RANGE_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        rrq_pkg::CFG_QUANT_BITS:  qbits_r <= cfg_wdata[rrq_pkg::QBITS_W-1:0];
        rrq_pkg::CFG_VALUE_RANGE: range_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [rrq_pkg::CODE_W:0] full_scale;
    qbits_eff = (qbits_r == '0 || qbits_r > rrq_pkg::QBITS_MAX) ? rrq_pkg::QBITS_MAX
                                                                 : qbits_r;
    range_eff = (range_r == '0) ? rrq_pkg::RANGE_ONE : range_r;
    full_scale = ((rrq_pkg::CODE_W+1)'(1) << qbits_eff) - 1'b1;
    qcfg.scale = full_scale[rrq_pkg::CODE_W-1:0];
    qcfg.den   = {range_eff, {(rrq_pkg::GUARD_BITS + 1){1'b0}}};
  end

  assign in_tready = !q_full;

  rrq_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .CW          (CW),
    .FW          (FW)
  ) u_front (
    .coord_x  (in_tdata[SAMPLE_WIDTH-1:0]),
    .coord_y  (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .rot_angle(in_tdata[2*SAMPLE_WIDTH +: ANGLE_WIDTH]),
    .item     (front_item)
  );

  rrq_fifo #(
    .WIDTH(FW),
    .DEPTH(rrq_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid),
    .push_data(front_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_item)
  );

  rrq_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .CW          (CW),
    .FW          (FW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(q_valid),
    .item      (q_item),
    .item_pop  (q_pop),
    .qcfg      (qcfg),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .code_x    (out_tdata[rrq_pkg::CODE_W-1:0]),
    .code_y    (out_tdata[2*rrq_pkg::CODE_W-1:rrq_pkg::CODE_W])
  );

endmodule

// ===== hdl/rrq_checker.sv =====
// Port-level checker for the rotary rotate-and-quantize top level, with its bind.
// Depends on rrq_pkg and rotary_rotate_and_quantize_top.
`timescale 1ns / 1ps
module rrq_checker #(
  parameter int IN_W  = 48,
  parameter int OUT_W = 2 * rrq_pkg::CODE_W
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [7:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not empty after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 8'd0)
    else $error("result without pending transaction");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !$isunknown(in_tdata))
    else $error("unknown bits in accepted input transaction");

endmodule

bind rotary_rotate_and_quantize_top rrq_checker #(
  .IN_W (((2*SAMPLE_WIDTH+ANGLE_WIDTH+7)/8)*8),
  .OUT_W(2*rrq_pkg::CODE_W)
) u_rrq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ===== tb/rrq_scoreboard.sv =====
// Scoreboard for the rotary rotate-and-quantize block: follows the register port,
// predicts the two codes of every input transaction and compares output transactions.
// Depends on rrq_pkg for widths and register indexes.
`timescale 1ns / 1ps
module rrq_scoreboard (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [47:0]                   in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [2*rrq_pkg::CODE_W-1:0]  out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [rrq_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rrq_pkg::RANGE_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import rrq_pkg::*;

  typedef struct {
    logic [CODE_W-1:0] code_x;
    logic [CODE_W-1:0] code_y;
  } code_pair_t;

  localparam bit [31:0] ARCTAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic [QBITS_W-1:0] quant_bits_q;
  logic [RANGE_W-1:0] value_range_q;
  code_pair_t         expected_codes [$];

  function automatic logic [CODE_W-1:0] quantize(longint v, longint r, longint s);
    longint num;
    longint q;
    num = v * s + (r <<< GUARD_BITS) * s + (r <<< GUARD_BITS);
    if (num < 0) return '0;
    q = num / (r <<< (GUARD_BITS + 1));
    if (q > s) q = s;
    return q[CODE_W-1:0];
  endfunction

  function automatic code_pair_t rotate_quantize(logic [15:0] xi, logic [15:0] yi,
                                                 logic [15:0] ai, logic [QBITS_W-1:0] qb,
                                                 logic [RANGE_W-1:0] rg);
    longint     x, y, px, py, t, z, dx, dy, r, s;
    bit [31:0]  a32, quad, resid;
    int         bits;
    code_pair_t res;
    x = longint'(signed'(xi));
    y = longint'(signed'(yi));
    a32 = {ai, 16'h0000};
    quad = ((a32 + 32'h20000000) >> 30) & 32'd3;
    resid = a32 - (quad << 30);
    z = longint'(signed'(resid));
    case (quad)
      32'd1: begin px = -y; py = x; end
      32'd2: begin px = -x; py = -y; end
      32'd3: begin px = y; py = -x; end
      default: begin px = x; py = y; end
    endcase
    px = px * 256;
    py = py * 256;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (z >= 0) begin
        t = px - dx;
        py = py + dy;
        z = z - longint'({32'h0, ARCTAN_TURN[i]});
      end else begin
        t = px + dx;
        py = py - dy;
        z = z + longint'({32'h0, ARCTAN_TURN[i]});
      end
      px = t;
    end
    px = (px * 64'sd636751 + 64'sd524288) >>> 20;
    py = (py * 64'sd636751 + 64'sd524288) >>> 20;
    bits = qb;
    if (bits == 0 || bits > 8) bits = 8;
    r = (rg == 0) ? 64'sd4096 : longint'(rg);
    s = (64'sd1 <<< bits) - 1;
    res.code_x = quantize(px, r, s);
    res.code_y = quantize(py, r, s);
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    code_pair_t want;
    if (!rst_n) begin
      quant_bits_q  <= QBITS_MAX;
      value_range_q <= RANGE_ONE;
      expected_codes.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_QUANT_BITS) quant_bits_q <= cfg_wdata[QBITS_W-1:0];
        else if (cfg_addr == CFG_VALUE_RANGE) value_range_q <= cfg_wdata;
      end
      if (in_tvalid && in_tready)
        expected_codes.push_back(rotate_quantize(in_tdata[15:0], in_tdata[31:16],
                                                 in_tdata[47:32], quant_bits_q,
                                                 value_range_q));
      if (out_tvalid && out_tready) begin
        if (expected_codes.size() == 0) begin
          report("unexpected transaction, code_x", out_tdata[7:0], -1);
        end else begin
          want = expected_codes.pop_front();
          if (out_tdata[7:0] !== want.code_x) report("code_x", out_tdata[7:0], want.code_x);
          if (out_tdata[15:8] !== want.code_y) report("code_y", out_tdata[15:8], want.code_y);
        end
      end
    end
    pending <= expected_codes.size();
  end
endmodule

// ===== tb/rotary_rotate_and_quantize_top_tb.sv =====
// Testbench top for the rotary rotate-and-quantize block: clock, reset, register
// writes, input and output stream traffic with idling and back-pressure, verdict.
// Depends on rrq_pkg, rotary_rotate_and_quantize_top and rrq_scoreboard.
`timescale 1ns / 1ps
module rotary_rotate_and_quantize_top_tb;
  import rrq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX   = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [47:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [2*CODE_W-1:0]  out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [RANGE_W-1:0]   cfg_wdata = '0;
  int                   fail_count;
  int                   pending;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   stall_req = 0;
  int                   cycles = 0;
  int                   range_now = 4096;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rotary_rotate_and_quantize_top dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata
  );

  rrq_scoreboard scoreboard (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .cfg_wr_en, .cfg_addr, .cfg_wdata, .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever stall_req moves on
  initial begin
    int seen_req;
    int hold_left;
    seen_req = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (stall_req != seen_req) begin
        seen_req = stall_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(logic [15:0] x, logic [15:0] y, logic [15:0] ang);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ang, y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RANGE_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == CFG_VALUE_RANGE) range_now = (val == 0) ? 4096 : val;
  endtask

  // mostly values near the range so codes spread out; the rest anywhere
  function automatic logic [15:0] pick_sample();
    int lim;
    lim = (range_now > 32767) ? 32767 : range_now + range_now / 4;
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($urandom_range(2 * lim) - lim);
  endfunction

  initial begin
    logic [15:0] edge_vals [6];
    logic [15:0] edge_angles [8];
    int          quant_set [8];
    int          range_set [8];
    edge_vals   = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000, 16'hF000};
    edge_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000,
                    16'h1FFF, 16'hE000};
    quant_set   = '{15, 1, 0, 4, 8, 9, 2, 6};
    range_set   = '{32767, 1, 0, 2048, 4096, 8192, 100, 20000};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of samples against key angles at reset settings
    for (int i = 0; i < 6; i++)
      send_item(edge_vals[i], edge_vals[5 - i], edge_angles[i]);
    for (int i = 0; i < 8; i++)
      send_item(16'h7FFF, 16'h8000, edge_angles[i]);
    drain();
    write_reg(CFG_QUANT_BITS, 15'd0);
    write_reg(CFG_VALUE_RANGE, 15'd0);
    write_reg(CFG_UNUSED_IDX, 15'h7FFF);
    write_reg(CFG_LAST_IDX, 15'h0001);
    for (int i = 0; i < 4; i++)
      send_item(edge_vals[i], edge_vals[i + 1], edge_angles[i + 4]);
    send_item(16'h5555, 16'hAAAA, 16'h5555);
    send_item(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    // long hold-off on the receiver while the sender keeps offering
    stall_req <= stall_req + 1;
    for (int i = 0; i < 80; i++) send_item(pick_sample(), pick_sample(), 16'($urandom));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_QUANT_BITS, 15'(quant_set[ph]));
      write_reg(CFG_VALUE_RANGE, 15'(range_set[ph]));
      for (int i = 0; i < 190; i++) begin
        if (i < 60) begin
          send_idle_pct = 6; recv_idle_pct = 45;
        end else if (i < 120) begin
          send_idle_pct = 45; recv_idle_pct = 6;
        end else begin
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        send_item(pick_sample(), pick_sample(), 16'($urandom));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== rotary_rotate_and_quantize_top.f =====
hdl/rrq_pkg.sv
hdl/rrq_fifo.sv
hdl/rrq_front.sv
hdl/rrq_back.sv
hdl/rotary_rotate_and_quantize_top.sv
hdl/rrq_checker.sv
tb/rrq_scoreboard.sv
tb/rotary_rotate_and_quantize_top_tb.sv
